// ----- hw/rtl/apt_pkg.sv -----
// Package for the absolute encoder position tracker.
// Holds the shared constants, codes and types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package apt_pkg;

    // Ticks in one revolution. Must be a power of two: wrapping is a bit mask.
    localparam int TICKS_PER_REV = 65536;
    localparam int POS_W         = $clog2(TICKS_PER_REV);
    localparam int STEP_W        = POS_W + 1;
    localparam int HALF_REV      = TICKS_PER_REV / 2;

    localparam int RAW_W   = 16;
    localparam int ERR_W   = 8;
    localparam int CFG_W   = 16;
    localparam int DIST_W  = 32;
    localparam int VEL_W   = 32;
    localparam int RATE_W  = 16;

    localparam int ERR_LIMIT     = 50;
    localparam int ERR_CNT_W     = 6;
    localparam int ERR_INVALID   = 0;
    localparam int ERR_TIMEOUT   = 1;
    localparam int SPIKE_PERIOD  = 100;
    localparam int SPIKE_CNT_W   = 7;
    localparam int STABLE_NEEDED = 3;
    localparam int STABLE_W      = 2;
    localparam int DECAY_MUL     = 7;
    localparam int VEL_SHIFT     = 3;

    localparam logic [CFG_W-1:0] MAX_STEP_RST = 16'd112;
    localparam logic [RATE_W-1:0] RATE_RST    = 16'd1000;

    typedef enum logic [1:0] {
        FUNC_ACQUIRE = 2'd0,
        FUNC_CLEAR   = 2'd1,
        FUNC_CALIB   = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        CFG_DIR      = 2'd0,
        CFG_OFFSET   = 2'd1,
        CFG_MAX_STEP = 2'd2,
        CFG_RATE     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [POS_W-1:0]         pos;
        logic signed [STEP_W-1:0] check;
        logic signed [STEP_W-1:0] delta;
        logic                     in_range;
        logic                     delta_zero;
    } t_step_info;

endpackage

`default_nettype wire

// ----- hw/rtl/apt_in_if.sv -----
// Input channel of the position tracker: one encoder sample per transfer.
// Depends on apt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface apt_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  func;
    logic [apt_pkg::RAW_W-1:0]   raw_position;
    logic [apt_pkg::ERR_W-1:0]   error_flags;

    modport source (output valid, func, raw_position, error_flags, input ready);
    modport sink   (input valid, func, raw_position, error_flags, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/apt_out_if.sv -----
// Output channel of the position tracker: one tracking result per transfer.
// Depends on apt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface apt_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [apt_pkg::DIST_W-1:0]   signed_distance;
    logic signed [apt_pkg::VEL_W-1:0]    velocity;
    logic                                all_ok;
    logic                                invalid_fault;
    logic                                timeout_fault;
    logic                                spike_warning;
    logic signed [apt_pkg::STEP_W-1:0]   spike_step;

    modport source (output valid, signed_distance, velocity, all_ok, invalid_fault,
                    timeout_fault, spike_warning, spike_step, input ready);
    modport sink   (input valid, signed_distance, velocity, all_ok, invalid_fault,
                    timeout_fault, spike_warning, spike_step, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/apt_step_calc.sv -----
// Position front end: offset removal, revolution wrap and step classification.
// Depends on apt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module apt_step_calc (
    input  wire logic [apt_pkg::RAW_W-1:0]  i_raw,
    input  wire logic [apt_pkg::CFG_W-1:0]  i_offset,
    input  wire logic [apt_pkg::POS_W-1:0]  i_last,
    input  wire logic [apt_pkg::POS_W-1:0]  i_sure,
    input  wire logic [apt_pkg::CFG_W-1:0]  i_max_step,
    output apt_pkg::t_step_info             o_info
);

    localparam int WIDE_W = apt_pkg::POS_W + 2;
    localparam int CMP_W  = (apt_pkg::CFG_W > WIDE_W ? apt_pkg::CFG_W : WIDE_W) + 2;

    logic [apt_pkg::RAW_W-1:0]  diff_raw;
    logic [apt_pkg::POS_W-1:0]  pos;
    logic signed [WIDE_W-1:0]   check_w;
    logic signed [WIDE_W-1:0]   delta_w;
    logic signed [CMP_W-1:0]    check_c;
    logic signed [CMP_W-1:0]    max_c;

    // Difference of two positions, brought into [-HALF_REV, HALF_REV].
    function automatic logic signed [WIDE_W-1:0] wrap_diff(
        input logic [apt_pkg::POS_W-1:0] a,
        input logic [apt_pkg::POS_W-1:0] b
    );
        logic signed [WIDE_W-1:0] d;
        begin
            d = $signed({2'b00, a}) - $signed({2'b00, b});
            if (d > $signed(WIDE_W'(apt_pkg::HALF_REV))) begin
                d = d - $signed(WIDE_W'(apt_pkg::TICKS_PER_REV));
            end else if (d < -$signed(WIDE_W'(apt_pkg::HALF_REV))) begin
                d = d + $signed(WIDE_W'(apt_pkg::TICKS_PER_REV));
            end
            return d;
        end
    endfunction

    always_comb begin
        diff_raw = i_raw - i_offset;
        pos      = diff_raw[apt_pkg::POS_W-1:0];
        check_w  = wrap_diff(pos, i_last);
        delta_w  = wrap_diff(pos, i_sure);
        check_c  = CMP_W'(check_w);
        max_c    = $signed(CMP_W'(i_max_step));

        o_info.pos        = pos;
        o_info.check      = check_w[apt_pkg::STEP_W-1:0];
        o_info.delta      = delta_w[apt_pkg::STEP_W-1:0];
        o_info.in_range   = (check_c >= -max_c) && (check_c <= max_c);
        o_info.delta_zero = (delta_w == '0);
    end

endmodule

`default_nettype wire

// ----- hw/rtl/apt_vel_filter.sv -----
// Velocity IIR filter: (7*v + sign*rate*delta) >>> 3, kept to 32 bits.
// Depends on apt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module apt_vel_filter (
    input  wire logic signed [apt_pkg::VEL_W-1:0]  i_vel,
    input  wire logic                              i_add_en,
    input  wire logic                              i_sgn_neg,
    input  wire logic [apt_pkg::RATE_W-1:0]        i_rate,
    input  wire logic signed [apt_pkg::STEP_W-1:0] i_delta,
    output      logic signed [apt_pkg::VEL_W-1:0]  o_vel
);

    localparam int DS_W   = apt_pkg::STEP_W + 1;
    localparam int PROD_W = DS_W + apt_pkg::RATE_W + 1;
    localparam int SUM_W  = apt_pkg::VEL_W + 5;

    logic signed [DS_W-1:0]   delta_s;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  vel_x;
    logic signed [SUM_W-1:0]  decay;
    logic signed [SUM_W-1:0]  sum;

    always_comb begin
        delta_s = i_sgn_neg ? -DS_W'(i_delta) : DS_W'(i_delta);
        prod    = PROD_W'(delta_s) * $signed({1'b0, i_rate});
        vel_x   = SUM_W'(i_vel);
        decay   = vel_x * $signed(SUM_W'(apt_pkg::DECAY_MUL));
        sum     = decay + (i_add_en ? SUM_W'(prod) : '0);
        o_vel   = sum[apt_pkg::VEL_SHIFT +: apt_pkg::VEL_W];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/abs_encoder_position_tracker_core.sv -----
// Absolute encoder position tracker, top level.
// Each result is registered and presented in the cycle after its sample transfer.
// Throughput: one sample per cycle; the output register frees the input side
// whenever the result is taken in the same cycle.
// Reset (synchronous, active low) restores all state but the result payload.
// Depends on apt_pkg, apt_in_if, apt_out_if, apt_step_calc and apt_vel_filter.
`timescale 1ns / 1ps
`default_nettype none

module abs_encoder_position_tracker_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [1:0]                  i_cfg_idx,
    input  wire logic [apt_pkg::CFG_W-1:0]   i_cfg_data,
    apt_in_if.sink                           i_sample,
    apt_out_if.source                        o_result
);

    // Configuration registers.
    logic [1:0]                  r_dir;
    logic [apt_pkg::CFG_W-1:0]   r_offset;
    logic [apt_pkg::CFG_W-1:0]   r_max_step;
    logic [apt_pkg::RATE_W-1:0]  r_rate;

    // Tracking state.
    logic [apt_pkg::DIST_W-1:0]       r_dist, n_dist;
    logic [apt_pkg::POS_W-1:0]        r_last, n_last;
    logic [apt_pkg::POS_W-1:0]        r_sure, n_sure;
    logic signed [apt_pkg::VEL_W-1:0] r_vel, n_vel;
    logic [apt_pkg::ERR_CNT_W-1:0]    r_inv_cnt, n_inv_cnt;
    logic [apt_pkg::ERR_CNT_W-1:0]    r_to_cnt, n_to_cnt;
    logic [apt_pkg::STABLE_W-1:0]     r_stable, n_stable;
    logic                             r_not_cal, n_not_cal;
    logic                             r_not_init, n_not_init;
    logic                             r_inv_latch, n_inv_latch;
    logic                             r_to_latch, n_to_latch;
    logic [apt_pkg::SPIKE_CNT_W-1:0]  r_spike_cnt, n_spike_cnt;

    // Result register.
    logic                               r_out_valid;
    logic signed [apt_pkg::DIST_W-1:0]  r_out_dist, n_out_dist;
    logic                               r_out_ok, n_out_ok;
    logic                               r_out_warn, n_out_warn;
    logic signed [apt_pkg::STEP_W-1:0]  r_out_spike, n_out_spike;

    logic                             in_fire;
    logic                             good;
    logic                             sgn_zero;
    logic                             sgn_neg;
    logic                             add_en;
    logic [apt_pkg::POS_W-1:0]        init_last;
    logic [apt_pkg::SPIKE_CNT_W-1:0]  spike_inc;
    logic [apt_pkg::STABLE_W:0]       stable_inc;
    logic signed [apt_pkg::VEL_W-1:0] filt_vel;
    apt_pkg::t_step_info              step;
    apt_pkg::t_func                   func;

    apt_step_calc u_step (
        .i_raw      (i_sample.raw_position),
        .i_offset   (r_offset),
        .i_last     (r_last),
        .i_sure     (r_sure),
        .i_max_step (r_max_step),
        .o_info     (step)
    );

    assign add_en = step.in_range && !step.delta_zero;

    apt_vel_filter u_vel (
        .i_vel     (r_vel),
        .i_add_en  (add_en),
        .i_sgn_neg (sgn_neg),
        .i_rate    (r_rate),
        .i_delta   (step.delta),
        .o_vel     (filt_vel)
    );

    assign sgn_zero = (r_dir == 2'b00);
    assign sgn_neg  = r_dir[1];
    assign good     = (i_sample.error_flags == '0);
    assign func     = apt_pkg::t_func'(i_sample.func);

    assign i_sample.ready = !r_out_valid || o_result.ready;
    assign in_fire        = i_sample.valid && i_sample.ready;

    always_comb begin
        n_dist      = r_dist;
        n_last      = r_last;
        n_sure      = r_sure;
        n_vel       = r_vel;
        n_inv_cnt   = r_inv_cnt;
        n_to_cnt    = r_to_cnt;
        n_stable    = r_stable;
        n_not_cal   = r_not_cal;
        n_not_init  = r_not_init;
        n_inv_latch = r_inv_latch;
        n_to_latch  = r_to_latch;
        n_spike_cnt = r_spike_cnt;
        n_out_warn  = 1'b0;
        n_out_spike = '0;
        init_last   = (r_stable == '0) ? step.pos : r_last;
        stable_inc  = {1'b0, r_stable} + 1'b1;
        spike_inc   = r_spike_cnt + 1'b1;

        case (func)
            apt_pkg::FUNC_CLEAR: begin
                n_inv_cnt   = '0;
                n_to_cnt    = '0;
                n_inv_latch = 1'b0;
                n_to_latch  = 1'b0;
            end
            apt_pkg::FUNC_CALIB: begin
                n_not_cal  = 1'b0;
                n_not_init = 1'b1;
            end
            apt_pkg::FUNC_ACQUIRE: begin
                if (!sgn_zero) begin
                    // Error run counters saturate one past the limit, then latch.
                    if (good) begin
                        n_inv_cnt = '0;
                        n_to_cnt  = '0;
                    end else begin
                        if (i_sample.error_flags[apt_pkg::ERR_INVALID]) begin
                            if (r_inv_cnt > apt_pkg::ERR_CNT_W'(apt_pkg::ERR_LIMIT)) begin
                                n_inv_latch = 1'b1;
                            end else begin
                                n_inv_cnt = r_inv_cnt + 1'b1;
                            end
                        end else begin
                            n_inv_cnt = '0;
                        end
                        if (i_sample.error_flags[apt_pkg::ERR_TIMEOUT]) begin
                            if (r_to_cnt > apt_pkg::ERR_CNT_W'(apt_pkg::ERR_LIMIT)) begin
                                n_to_latch = 1'b1;
                            end else begin
                                n_to_cnt = r_to_cnt + 1'b1;
                            end
                        end else begin
                            n_to_cnt = '0;
                        end
                    end

                    if (r_not_init) begin
                        if (!good) begin
                            n_stable = '0;
                        end else begin
                            n_last = init_last;
                            if (init_last != step.pos) begin
                                n_stable = '0;
                            end else if (stable_inc >= (apt_pkg::STABLE_W + 1)'(
                                         apt_pkg::STABLE_NEEDED)) begin
                                n_last     = step.pos;
                                n_sure     = step.pos;
                                n_dist     = apt_pkg::DIST_W'(step.pos);
                                n_stable   = '0;
                                n_not_init = 1'b0;
                            end else begin
                                n_stable = stable_inc[apt_pkg::STABLE_W-1:0];
                            end
                        end
                        n_vel = '0;
                    end else if (good) begin
                        n_last = step.pos;
                        n_vel  = filt_vel;
                        if (step.in_range) begin
                            if (!step.delta_zero) begin
                                n_sure = step.pos;
                                n_dist = r_dist + apt_pkg::DIST_W'(step.delta);
                            end
                        end else if (spike_inc >= apt_pkg::SPIKE_CNT_W'(
                                     apt_pkg::SPIKE_PERIOD)) begin
                            n_spike_cnt = '0;
                            n_out_warn  = 1'b1;
                            n_out_spike = step.check;
                        end else begin
                            n_spike_cnt = spike_inc;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        if (sgn_zero) begin
            n_out_dist = '0;
        end else if (sgn_neg) begin
            n_out_dist = -$signed(n_dist);
        end else begin
            n_out_dist = $signed(n_dist);
        end
        n_out_ok = !sgn_zero && !n_not_cal && !n_not_init && !n_inv_latch && !n_to_latch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir      <= 2'b00;
            r_offset   <= '0;
            r_max_step <= apt_pkg::MAX_STEP_RST;
            r_rate     <= apt_pkg::RATE_RST;
        end else if (i_cfg_we) begin
            case (apt_pkg::t_cfg_idx'(i_cfg_idx))
                apt_pkg::CFG_DIR:      r_dir      <= i_cfg_data[1:0];
                apt_pkg::CFG_OFFSET:   r_offset   <= i_cfg_data;
                apt_pkg::CFG_MAX_STEP: r_max_step <= i_cfg_data;
                apt_pkg::CFG_RATE:     r_rate     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist      <= '0;
            r_last      <= '0;
            r_sure      <= '0;
            r_vel       <= '0;
            r_inv_cnt   <= '0;
            r_to_cnt    <= '0;
            r_stable    <= '0;
            r_not_cal   <= 1'b1;
            r_not_init  <= 1'b1;
            r_inv_latch <= 1'b0;
            r_to_latch  <= 1'b0;
            r_spike_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_dist      <= n_dist;
                r_last      <= n_last;
                r_sure      <= n_sure;
                r_vel       <= n_vel;
                r_inv_cnt   <= n_inv_cnt;
                r_to_cnt    <= n_to_cnt;
                r_stable    <= n_stable;
                r_not_cal   <= n_not_cal;
                r_not_init  <= n_not_init;
                r_inv_latch <= n_inv_latch;
                r_to_latch  <= n_to_latch;
                r_spike_cnt <= n_spike_cnt;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; it only changes on a sample transfer.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_dist  <= n_out_dist;
            r_out_ok    <= n_out_ok;
            r_out_warn  <= n_out_warn;
            r_out_spike <= n_out_spike;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.signed_distance = r_out_dist;
    assign o_result.velocity        = r_vel;
    assign o_result.all_ok          = r_out_ok;
    assign o_result.invalid_fault   = r_inv_latch;
    assign o_result.timeout_fault   = r_to_latch;
    assign o_result.spike_warning   = r_out_warn;
    assign o_result.spike_step      = r_out_spike;

endmodule

`default_nettype wire
